FILE: rtl/pfc_pkg.sv
package pfc_pkg;

    // Input transaction: function code and raw byte
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] in_char;
    } in_t;

    // Result transaction: one cipher letter
    typedef struct packed {
        logic [6:0] out_char;
        logic       last;
    } out_t;

    // Function codes
    typedef enum logic [1:0] {
        FUNC_KEY = 2'd0,
        FUNC_MSG = 2'd1,
        FUNC_END = 2'd2
    } func_t;

    // Folded letter: index 0..25 and a flag for a real letter
    typedef struct packed {
        logic       valid;
        logic [4:0] idx;
    } letter_t;

    localparam logic [4:0] LET_I      = 5'd8;
    localparam logic [4:0] LET_J      = 5'd9;
    localparam logic [4:0] LET_X      = 5'd23;
    localparam logic [4:0] LET_Z      = 5'd25;
    localparam logic [4:0] GRID_CELLS = 5'd25;
    localparam logic [6:0] ASCII_A    = 7'd65;
    localparam logic [2:0] SHIFT_ENC  = 3'd1;
    localparam logic [2:0] SHIFT_DEC  = 3'd4;

    // Upper or lower case letter to index; anything else is flagged invalid
    function automatic letter_t fold_letter(input logic [7:0] b);
        letter_t    r;
        logic [7:0] d;
        r = '0;
        d = 8'd0;
        if (b >= 8'd65 && b <= 8'd90) begin
            d = b - 8'd65;
            r.valid = 1'b1;
            r.idx = d[4:0];
        end else if (b >= 8'd97 && b <= 8'd122) begin
            d = b - 8'd97;
            r.valid = 1'b1;
            r.idx = d[4:0];
        end
        return r;
    endfunction

    // Row of a grid cell 0..24
    function automatic logic [2:0] cell_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    // Column of a grid cell 0..24
    function automatic logic [2:0] cell_col(input logic [4:0] p);
        logic [4:0] base;
        logic [4:0] c;
        base = 5'd0;
        c = 5'd0;
        if (p >= 5'd20)      base = 5'd20;
        else if (p >= 5'd15) base = 5'd15;
        else if (p >= 5'd10) base = 5'd10;
        else if (p >= 5'd5)  base = 5'd5;
        c = p - base;
        return c[2:0];
    endfunction

    // (v + sh) mod 5 for v, sh below 5
    function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] sh);
        logic [3:0] s;
        logic [3:0] w;
        s = {1'b0, v} + {1'b0, sh};
        w = (s >= 4'd5) ? (s - 4'd5) : s;
        return w[2:0];
    endfunction

    // Cell index row*5+col
    function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

FILE: rtl/playfair_digraph_cipher_top.sv
// Playfair cipher over a 5x5 key grid with I and J sharing a cell. Key bytes
// (func 0) build the grid in order of first appearance; the first message
// byte (func 1) completes it with the unused letters, which walks the whole
// alphabet once at one letter per cycle. Message letters are paired, X splits
// a doubled letter in encrypt mode, and end of message (func 2) pads an open
// pair with X. Each pair gives two result transactions, the second flagged
// last. A pair goes through the single read port of the letter position
// memory and of the grid memory, each read twice per pair, and its results
// wait on the output handshake. Input is not accepted while a transaction is
// in progress. The user must write decrypt_mode (cfg_wdata) only while the
// block is idle; the block itself does not enforce this.
module playfair_digraph_cipher_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  pfc_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pfc_pkg::out_t  m_data
);
    import pfc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FILL, ST_PAIR, ST_POS_A, ST_POS_B, ST_CALC,
        ST_GRID_A, ST_GRID_B, ST_SEND_A, ST_SEND_B
    } state_t;

    state_t      state_reg;
    logic        mode_reg;
    logic [25:0] used_reg;
    logic [4:0]  fill_reg;
    logic        table_ready_reg;
    logic [4:0]  pending_reg;
    logic        pending_valid_reg;
    logic [4:0]  walk_reg;
    logic [4:0]  msg_let_reg;
    logic [4:0]  a_reg;
    logic [4:0]  b_reg;
    logic [4:0]  pa_reg;
    logic [4:0]  oa_reg;
    logic [4:0]  ob_reg;
    logic        m_valid_reg;
    out_t        m_data_reg;

    // Memories: cell of each letter, letter of each cell
    logic [4:0]  pos_mem [26];
    logic [4:0]  grid_mem [25];
    logic [4:0]  pos_q;
    logic [4:0]  grid_q;

    letter_t     in_let;
    logic [4:0]  in_let_ij;
    logic        clear_key;
    logic        place_cand;
    logic        place_en;
    logic [4:0]  place_let;
    logic [25:0] base_used;
    logic [4:0]  base_fill;
    logic [25:0] used_next;
    logic [4:0]  fill_next;
    logic [4:0]  pos_rd_addr;
    logic [4:0]  grid_rd_addr;
    logic [2:0]  shift;
    logic [2:0]  ra, ca, rb, cb;
    logic [4:0]  oa_next;
    logic [4:0]  ob_next;
    logic        in_xfer;
    logic        out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid_reg && m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Input folding, J read as I
    always_comb begin
        in_let = fold_letter(s_data.in_char);
        in_let_ij = (in_let.idx == LET_J) ? LET_I : in_let.idx;
    end

    // Letter placement: from a key byte or from the completion walk
    always_comb begin
        clear_key = 1'b0;
        place_cand = 1'b0;
        place_let = in_let_ij;
        if (state_reg == ST_IDLE && in_xfer && s_data.func == FUNC_KEY && in_let.valid) begin
            clear_key = table_ready_reg;
            place_cand = 1'b1;
        end else if (state_reg == ST_FILL) begin
            place_let = walk_reg;
            place_cand = (walk_reg != LET_J);
        end
        base_used = clear_key ? '0 : used_reg;
        base_fill = clear_key ? 5'd0 : fill_reg;
        place_en = place_cand && !base_used[place_let] && (base_fill < GRID_CELLS);
        used_next = base_used | (place_en ? (26'd1 << place_let) : 26'd0);
        fill_next = base_fill + {4'd0, place_en};
    end

    // Read addresses
    assign pos_rd_addr  = (state_reg == ST_POS_A) ? a_reg : b_reg;
    assign grid_rd_addr = (state_reg == ST_GRID_A) ? oa_reg : ob_reg;

    // Row, column and rectangle rules
    always_comb begin
        shift = mode_reg ? SHIFT_DEC : SHIFT_ENC;
        ra = cell_row(pa_reg);
        ca = cell_col(pa_reg);
        rb = cell_row(pos_q);
        cb = cell_col(pos_q);
        if (ra == rb) begin
            oa_next = cell_index(ra, add_mod5(ca, shift));
            ob_next = cell_index(rb, add_mod5(cb, shift));
        end else if (ca == cb) begin
            oa_next = cell_index(add_mod5(ra, shift), ca);
            ob_next = cell_index(add_mod5(rb, shift), cb);
        end else begin
            oa_next = cell_index(ra, cb);
            ob_next = cell_index(rb, ca);
        end
    end

    // Position memory
    always_ff @(posedge aclk) begin
        if (place_en) begin
            pos_mem[place_let] <= base_fill;
        end
        pos_q <= pos_mem[pos_rd_addr];
    end

    // Grid memory
    always_ff @(posedge aclk) begin
        if (place_en) begin
            grid_mem[base_fill] <= place_let;
        end
        grid_q <= grid_mem[grid_rd_addr];
    end

    // Sequencer, key state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg <= 1'b0;
            used_reg <= '0;
            fill_reg <= 5'd0;
            table_ready_reg <= 1'b0;
            pending_reg <= 5'd0;
            pending_valid_reg <= 1'b0;
            walk_reg <= 5'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            used_reg <= used_next;
            fill_reg <= fill_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        case (s_data.func)
                            FUNC_KEY: begin
                                if (in_let.valid && table_ready_reg) begin
                                    table_ready_reg <= 1'b0;
                                    pending_reg <= 5'd0;
                                    pending_valid_reg <= 1'b0;
                                end
                            end
                            FUNC_MSG: begin
                                if (in_let.valid) begin
                                    msg_let_reg <= in_let_ij;
                                    walk_reg <= 5'd0;
                                    state_reg <= table_ready_reg ? ST_PAIR : ST_FILL;
                                end
                            end
                            // end mark closes an open pair whatever its byte
                            FUNC_END: begin
                                if (pending_valid_reg) begin
                                    a_reg <= pending_reg;
                                    b_reg <= LET_X;
                                    pending_valid_reg <= 1'b0;
                                    state_reg <= ST_POS_A;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FILL: begin
                    walk_reg <= walk_reg + 5'd1;
                    if (walk_reg == LET_Z) begin
                        table_ready_reg <= 1'b1;
                        state_reg <= ST_PAIR;
                    end
                end
                ST_PAIR: begin
                    if (!pending_valid_reg) begin
                        pending_reg <= msg_let_reg;
                        pending_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else if (!mode_reg && pending_reg == msg_let_reg) begin
                        // doubled letter: split by X, letter stays pending
                        a_reg <= msg_let_reg;
                        b_reg <= LET_X;
                        state_reg <= ST_POS_A;
                    end else begin
                        a_reg <= pending_reg;
                        b_reg <= msg_let_reg;
                        pending_valid_reg <= 1'b0;
                        state_reg <= ST_POS_A;
                    end
                end
                ST_POS_A: begin
                    state_reg <= ST_POS_B;
                end
                ST_POS_B: begin
                    pa_reg <= pos_q;
                    state_reg <= ST_CALC;
                end
                ST_CALC: begin
                    oa_reg <= oa_next;
                    ob_reg <= ob_next;
                    state_reg <= ST_GRID_A;
                end
                ST_GRID_A: begin
                    state_reg <= ST_GRID_B;
                end
                ST_GRID_B: begin
                    m_valid_reg <= 1'b1;
                    m_data_reg.out_char <= ASCII_A + {2'b00, grid_q};
                    m_data_reg.last <= 1'b0;
                    state_reg <= ST_SEND_A;
                end
                ST_SEND_A: begin
                    if (out_xfer) begin
                        m_data_reg.out_char <= ASCII_A + {2'b00, grid_q};
                        m_data_reg.last <= 1'b1;
                        state_reg <= ST_SEND_B;
                    end
                end
                ST_SEND_B: begin
                    if (out_xfer) begin
                        m_valid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Every placed letter counts one cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_reg) == {27'd0, fill_reg})
        else $error("usage flags disagree with fill count");

    // A complete grid holds all 25 cells
    assert property (@(posedge aclk) disable iff (!aresetn)
        table_ready_reg |-> (fill_reg == GRID_CELLS))
        else $error("grid marked ready while not full");

    // A pair always opens with its first letter
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> !m_data_reg.last)
        else $error("pair opened on its second letter");

    // The first letter of a pair is always followed by the second
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xfer && !m_data_reg.last) |=> (m_valid_reg && m_data_reg.last))
        else $error("second letter of pair missing");

    // No input is taken while a result is outstanding
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !s_ready)
        else $error("input accepted with result pending");
`endif

endmodule

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    // Unused function code, must be ignored by the block
    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    // Cycles with no transaction on either channel before the run is abandoned
    localparam int         STALL_LIMIT = 4000;
    // Quiet cycles allowed for a grid walk still in progress
    localparam int         SETTLE      = 40;
    localparam int         RANDOM_ITEMS = 1060;

    logic  aclk      = 1'b0;
    logic  aresetn   = 1'b0;
    logic  cfg_we    = 1'b0;
    logic  cfg_wdata = 1'b0;
    logic  s_valid   = 1'b0;
    logic  s_ready;
    in_t   s_data    = '0;
    logic  m_valid;
    logic  m_ready   = 1'b0;
    out_t  m_data;

    playfair_digraph_cipher_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state: key grid, placement flags and the open pair
    int   grid_cell [25];
    int   cell_of_letter [26];
    bit   letter_placed [26];
    int   cells_filled;
    bit   grid_complete;
    int   open_letter;
    bit   open_valid;
    bit   mode_decrypt;

    out_t expected_letters [$];
    int   fault_count     = 0;
    int   meaningful_sent = 0;
    int   burst_left      = 0;
    int   idle_cycles     = 0;

    // Receiver stall pattern state
    int   pattern_kind = 0;
    int   pattern_left = 0;
    int   cycle_count  = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fault_count < 50)
            $display("ERROR %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        fault_count++;
    endtask

    // 0..25 for a letter of either case, 26 otherwise
    function automatic int letter_index(input logic [7:0] b);
        if (b >= 8'd65 && b <= 8'd90)  return int'(b) - 65;
        if (b >= 8'd97 && b <= 8'd122) return int'(b) - 97;
        return 26;
    endfunction

    function automatic logic [7:0] letter_byte(input int l);
        return ($urandom % 2) ? 8'(65 + l) : 8'(97 + l);
    endfunction

    task automatic clear_grid();
        for (int i = 0; i < 25; i++) grid_cell[i] = 0;
        for (int i = 0; i < 26; i++) begin
            cell_of_letter[i] = 0;
            letter_placed[i] = 1'b0;
        end
        cells_filled = 0;
        grid_complete = 1'b0;
        open_letter = 0;
        open_valid = 1'b0;
    endtask

    task automatic place_letter(input int l);
        if (l < 26 && !letter_placed[l] && cells_filled < 25) begin
            grid_cell[cells_filled] = l;
            cell_of_letter[l] = cells_filled;
            letter_placed[l] = 1'b1;
            cells_filled++;
        end
    endtask

    // Fill the remaining cells alphabetically, J shares the I cell
    task automatic complete_grid();
        for (int l = 0; l < 26; l++)
            if (l != int'(LET_J)) place_letter(l);
        grid_complete = 1'b1;
    endtask

    // Row, column and rectangle rules; two letters queued per pair
    task automatic push_pair(input int a, input int b);
        int   pa, pb, ra, ca, rb, cb, sh, oa, ob;
        out_t r;
        pa = cell_of_letter[a];
        pb = cell_of_letter[b];
        ra = pa / 5;
        ca = pa % 5;
        rb = pb / 5;
        cb = pb % 5;
        sh = mode_decrypt ? 4 : 1;
        if (ra == rb) begin
            oa = grid_cell[ra * 5 + (ca + sh) % 5];
            ob = grid_cell[rb * 5 + (cb + sh) % 5];
        end else if (ca == cb) begin
            oa = grid_cell[((ra + sh) % 5) * 5 + ca];
            ob = grid_cell[((rb + sh) % 5) * 5 + cb];
        end else begin
            oa = grid_cell[ra * 5 + cb];
            ob = grid_cell[rb * 5 + ca];
        end
        r.out_char = ASCII_A + 7'(oa);
        r.last = 1'b0;
        expected_letters.insert(expected_letters.size(), r);
        r.out_char = ASCII_A + 7'(ob);
        r.last = 1'b1;
        expected_letters.insert(expected_letters.size(), r);
    endtask

    // Expected letters for one accepted input transaction
    task automatic cipher_predict(input in_t item);
        int l;
        l = letter_index(item.in_char);
        case (item.func)
            FUNC_KEY: begin
                if (l < 26) begin
                    if (grid_complete) clear_grid();
                    if (l == int'(LET_J)) l = int'(LET_I);
                    place_letter(l);
                end
            end
            FUNC_MSG: begin
                if (l < 26) begin
                    if (!grid_complete) complete_grid();
                    if (l == int'(LET_J)) l = int'(LET_I);
                    if (!open_valid) begin
                        open_letter = l;
                        open_valid = 1'b1;
                    end else if (!mode_decrypt && open_letter == l) begin
                        // doubled letter: split with X, the new one stays open
                        push_pair(l, int'(LET_X));
                    end else begin
                        open_valid = 1'b0;
                        push_pair(open_letter, l);
                    end
                end
            end
            FUNC_END: begin
                if (open_valid) begin
                    open_valid = 1'b0;
                    push_pair(open_letter, int'(LET_X));
                end
            end
            default: ;
        endcase
    endtask

    // One input transaction, with random bursts and gaps on the sender side
    task automatic send_item(input logic [1:0] f, input logic [7:0] b);
        in_t item;
        int  gap;
        item.func = f;
        item.in_char = b;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        cipher_predict(item);
        if (f == FUNC_END || ((f == FUNC_KEY || f == FUNC_MSG) && letter_index(b) < 26))
            meaningful_sent++;
    endtask

    // Hold the sender off until every expected letter is out and the block is quiet
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_letters.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_mode(input bit m);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        mode_decrypt = m;
        cfg_we <= 1'b0;
    endtask

    // Message before any key: grid from the alphabet alone
    task automatic test_alphabet_grid();
        send_item(FUNC_MSG, "h");
        send_item(FUNC_MSG, "J");
        send_item(FUNC_MSG, "z");
        send_item(FUNC_MSG, "z");
        send_item(FUNC_END, "z");
    endtask

    // New key over a complete grid, J folded into I, repeats skipped
    task automatic test_keyed_encrypt();
        send_item(FUNC_KEY, "p");
        send_item(FUNC_KEY, "L");
        send_item(FUNC_KEY, "a");
        send_item(FUNC_KEY, "y");
        send_item(FUNC_KEY, "j");
        send_item(FUNC_KEY, "I");
        send_item(FUNC_MSG, "e");
        send_item(FUNC_MSG, "E");
        send_item(FUNC_END, 8'h00);
    endtask

    // Mode change with a letter open, equal pair in decrypt, key clearing an open pair
    task automatic test_mode_mid_pair();
        send_item(FUNC_MSG, "q");
        set_mode(1'b1);
        send_item(FUNC_MSG, "w");
        send_item(FUNC_MSG, "c");
        send_item(FUNC_MSG, "c");
        send_item(FUNC_MSG, "d");
        send_item(FUNC_KEY, "m");
        send_item(FUNC_MSG, "N");
        send_item(FUNC_END, "q");
        set_mode(1'b0);
    endtask

    // Spare function code and non-letters around the letter ranges
    task automatic test_ignored_bytes();
        send_item(FUNC_SPARE, "A");
        send_item(FUNC_KEY, 8'h00);
        send_item(FUNC_MSG, 8'hFF);
        send_item(FUNC_MSG, "@");
        send_item(FUNC_MSG, "{");
        send_item(FUNC_END, "Z");
    endtask

    // Random keys and messages, mostly well formed, with noise and mode changes
    task automatic test_random_traffic();
        int target, len, l, prev;
        target = meaningful_sent + RANDOM_ITEMS;
        while (meaningful_sent < target) begin
            if ($urandom % 8 == 0) set_mode(1'($urandom % 2));
            else if ($urandom % 10 == 0) wait_idle();
            if ($urandom % 3 == 0) begin
                len = $urandom_range(1, 15);
                for (int i = 0; i < len; i++) begin
                    if ($urandom % 8 == 0)
                        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    send_item(FUNC_KEY, letter_byte($urandom % 26));
                end
            end
            len = $urandom_range(1, 24);
            prev = 26;
            for (int i = 0; i < len; i++) begin
                if ($urandom % 10 == 0)
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                if (prev < 26 && $urandom % 4 == 0) l = prev;
                else if ($urandom % 3 == 0) l = $urandom_range(0, 9);
                else l = $urandom % 26;
                send_item(FUNC_MSG, letter_byte(l));
                prev = l;
            end
            if ($urandom % 8 != 0) send_item(FUNC_END, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        clear_grid();
        mode_decrypt = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_mode(1'b0);
        test_alphabet_grid();
        test_keyed_encrypt();
        test_mode_mid_pair();
        test_ignored_bytes();
        test_random_traffic();
        wait_idle();
        if (expected_letters.size() != 0)
            report_mismatch("letters never delivered", expected_letters.size(), 0);
        if (fault_count == 0)
            $display("playfair_digraph_cipher_top verification clean");
        else
            $display("playfair_digraph_cipher_top verification failed");
        $finish;
    end

    // Receiver: ready pattern picked at random from four kinds, changed when its run ends
    always @(posedge aclk) begin
        if (pattern_left == 0) begin
            pattern_kind <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(20, 200);
        end else begin
            pattern_left <= pattern_left - 1;
        end
        case (pattern_kind)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom % 2;
            2:       m_ready <= (cycle_count % 7) < 4;
            default: m_ready <= ($urandom % 4) == 0;
        endcase
        cycle_count <= cycle_count + 1;
    end

    // Result checker: each letter against the oldest expectation
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_letters.size() == 0) begin
                report_mismatch("unexpected letter", int'(m_data.out_char), 0);
            end else begin
                want = expected_letters.pop_front();
                if (m_data.out_char !== want.out_char)
                    report_mismatch("out_char", int'(m_data.out_char), int'(want.out_char));
                if (m_data.last !== want.last)
                    report_mismatch("last", int'(m_data.last), int'(want.last));
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("playfair_digraph_cipher_top verification failed");
                $finish;
            end
        end
    end

endmodule

FILE: filelist.f
rtl/pfc_pkg.sv
rtl/playfair_digraph_cipher_top.sv
sim/testbench.sv
